// ===== hw/rtl/sgb_pkg.sv =====
// Shared types, constants and helpers of the separable Gaussian blur core.
package sgb_pkg;

  localparam int RADIUS_DEF      = 5;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int MIN_DIM     = 16;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MODE_W      = 2;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ROW_W       = 12;
  localparam int COL_FIELD_W = 12;
  localparam int RING_FIELD_W = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO    = 2'd0,
    MODE_REFLECT = 2'd1,
    MODE_RENORM  = 2'd2,
    MODE_OFF     = 2'd3
  } border_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BORDER_MODE = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_VERT_NEAR   = 3'd3,
    REG_VERT_FAR    = 3'd4,
    REG_HORZ_NEAR   = 3'd5,
    REG_HORZ_FAR    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TAPS,
    BK_FLUSH,
    BK_DIV,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [WIDTH_W-1:0]    width;
    logic [HEIGHT_W-1:0]   height;
    logic [CFG_DATA_W-1:0] vert_near;
    logic [CFG_DATA_W-1:0] vert_far;
    logic [CFG_DATA_W-1:0] horz_near;
    logic [CFG_DATA_W-1:0] horz_far;
  } cfg_t;

  // one queued job: optional line store write plus optional window computation
  typedef struct packed {
    logic [7:0]              pix;
    logic                    wr;
    logic [RING_FIELD_W-1:0] wring;
    logic [COL_FIELD_W-1:0]  wcol;
    logic                    first;
    logic                    comp;
    logic [ROW_W-1:0]        orow;
    logic [COL_FIELD_W-1:0]  ocol;
    logic [RING_FIELD_W-1:0] oring;
    logic                    last;
  } job_t;

  function automatic logic [HEIGHT_W-1:0] clamp_dim(input logic [HEIGHT_W-1:0] v,
                                                    input logic [HEIGHT_W-1:0] hi);
    logic [HEIGHT_W-1:0] r;
    if (v < HEIGHT_W'(MIN_DIM)) r = HEIGHT_W'(MIN_DIM);
    else if (v > hi)            r = hi;
    else                        r = v;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sgb_fifo.sv =====
// Short job queue between the classifying front and the filtering back.
module sgb_fifo import sgb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      if ((push && !full) && !(pop && !empty))      cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/sgb_front.sv =====
// Front end: accepts beats, tracks raster position and queues write/compute jobs.
module sgb_front import sgb_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel,
  input  logic       in_drain,
  output logic       q_push,
  output job_t       q_data,
  input  logic       q_full
);

  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int RING_W = $clog2(TAPS);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int POS_W  = $clog2((MAX_HEIGHT + RADIUS + 1) * MAX_WIDTH);

  logic [HEIGHT_W-1:0] in_row_r;
  logic [COL_W-1:0]    in_col_r;
  logic [RING_W-1:0]   in_ring_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [RING_W-1:0]   out_ring_r;
  logic [POS_W-1:0]    pos_r, lag_r;
  logic [WID_W-1:0]    lat_w_r;
  logic [HEIGHT_W-1:0] lat_h_r;

  logic                first, ignore, wr, comp, last, take;
  logic [WID_W-1:0]    w_c;
  logic [HEIGHT_W-1:0] h_c;

  always_comb begin
    first  = (in_row_r == '0) && (in_col_r == '0);
    w_c    = first ? WID_W'(clamp_dim(HEIGHT_W'(cfg.width), HEIGHT_W'(MAX_WIDTH))) : lat_w_r;
    h_c    = first ? clamp_dim(cfg.height, HEIGHT_W'(MAX_HEIGHT)) : lat_h_r;
    wr     = (in_row_r < h_c);
    ignore = in_drain && wr;
    comp   = !first && (pos_r >= lag_r);
    last   = comp && (HEIGHT_W'(out_row_r) == h_c - 1'b1)
                  && (WID_W'(out_col_r) == w_c - 1'b1);
    in_ready = !q_full;
    take   = in_valid && in_ready && !ignore;
    q_push = take && (wr || comp);
    q_data.pix   = in_pixel;
    q_data.wr    = wr;
    q_data.wring = RING_FIELD_W'(in_ring_r);
    q_data.wcol  = COL_FIELD_W'(in_col_r);
    q_data.first = first;
    q_data.comp  = comp;
    q_data.orow  = out_row_r;
    q_data.ocol  = COL_FIELD_W'(out_col_r);
    q_data.oring = RING_FIELD_W'(out_ring_r);
    q_data.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
      pos_r      <= '0;
      lag_r      <= '0;
      lat_w_r    <= '0;
      lat_h_r    <= '0;
    end else if (take) begin
      if (first) begin
        lat_w_r <= w_c;
        lat_h_r <= h_c;
        lag_r   <= POS_W'(w_c) * POS_W'(RADIUS) + POS_W'(RADIUS);
      end
      if (last) begin
        in_row_r   <= '0;
        in_col_r   <= '0;
        in_ring_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_ring_r <= '0;
        pos_r      <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
        if (WID_W'(in_col_r) == w_c - 1'b1) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 1'b1;
          in_ring_r <= (in_ring_r == RING_W'(TAPS - 1)) ? '0 : in_ring_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (comp) begin
          if (WID_W'(out_col_r) == w_c - 1'b1) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_ring_r <= (out_ring_r == RING_W'(TAPS - 1)) ? '0 : out_ring_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sgb_back.sv =====
// Back end: line store, tap-serial weighted sum, renormalizing divide, output register.
module sgb_back import sgb_pkg::*; #(
  parameter int RADIUS      = RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pixel,
  output logic       out_frame_end
);

  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int RING_W = $clog2(TAPS);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int MAG_W  = $clog2(RADIUS + 1);
  localparam int OFF_W  = MAG_W + 1;
  localparam int SW     = 15;
  localparam int RS_W   = RING_W + 2;
  localparam int PROD_W = 2 * WEIGHT_BITS;
  localparam int DEN_W  = PROD_W + $clog2(TAPS * TAPS);
  localparam int NUM_W  = DEN_W + 8;
  localparam logic signed [OFF_W-1:0] R_POS = OFF_W'(RADIUS);
  localparam logic signed [OFF_W-1:0] R_NEG = -OFF_W'(RADIUS);
  localparam logic signed [SW-1:0]    ONE_S = SW'(1);

  function automatic logic signed [SW-1:0] refl(input logic signed [SW-1:0] ctr,
                                                input logic signed [SW-1:0] off,
                                                input logic signed [SW-1:0] size);
    logic signed [SW-1:0] r;
    r = ctr + off;
    if (r > size - ONE_S) r = ctr - off;
    else if (r < 0)       r = -r;
    if (r < 0)                 r = '0;
    else if (r > size - ONE_S) r = size - ONE_S;
    return r;
  endfunction

  logic [7:0] mem [TAPS][MAX_WIDTH];

  back_state_t state_r, state_nxt;

  logic [MODE_W-1:0]      lat_mode_r;
  logic [WID_W-1:0]       lat_w_r;
  logic [HEIGHT_W-1:0]    lat_h_r;
  logic [WEIGHT_BITS-1:0] wv_r [RADIUS+1];
  logic [WEIGHT_BITS-1:0] wh_r [RADIUS+1];

  logic [ROW_W-1:0]        o_row_r;
  logic [COL_W-1:0]        o_col_r;
  logic [RING_W-1:0]       o_ring_r;
  logic                    o_last_r;
  logic signed [OFF_W-1:0] ta_r, tb_r;

  logic              s1_v_r, s1_use_r, s2_v_r;
  logic [PROD_W-1:0] wp_r, wpd_r;
  logic [7:0]        rd_r;
  logic [PROD_W+7:0] prod_r;
  logic [NUM_W-1:0]  num_r, rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [7:0]        q_r;
  logic [2:0]        k_r;

  logic       out_valid_r, out_last_r;
  logic [7:0] out_pix_r;

  // control decode
  logic pop, start, issue, last_tap, flushed, load;

  // tap address path
  logic signed [SW-1:0]   row_c, col_c, ri0, ci0, ri, ci, roff;
  logic signed [RS_W-1:0] rs;
  logic                   in_r, in_c, use_tap;
  logic [RING_W-1:0]      ring_idx;
  logic [COL_W-1:0]       col_idx;
  logic [MAG_W-1:0]       ma, mb;
  logic [NUM_W-1:0]       dsh, sh;
  logic [7:0]             res;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_empty && q_data.comp) state_nxt = BK_TAPS;
      BK_TAPS:  if (last_tap) state_nxt = BK_FLUSH;
      BK_FLUSH: begin
        if (flushed) begin
          state_nxt = (lat_mode_r == MODE_RENORM && den_r != '0) ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV:   if (k_r == '0) state_nxt = BK_OUT;
      BK_OUT:   if (load) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == BK_IDLE) && !q_empty;
    start    = pop && q_data.comp;
    issue    = (state_r == BK_TAPS);
    last_tap = issue && (ta_r == R_POS) && (tb_r == R_POS);
    flushed  = !s1_v_r && !s2_v_r;
    load     = (state_r == BK_OUT) && (!out_valid_r || out_ready);
    q_pop    = pop;
  end

  always_comb begin
    row_c = $signed(SW'(o_row_r));
    col_c = $signed(SW'(o_col_r));
    ri0   = row_c + SW'(ta_r);
    ci0   = col_c + SW'(tb_r);
    in_r  = (ri0 >= 0) && (ri0 < $signed(SW'(lat_h_r)));
    in_c  = (ci0 >= 0) && (ci0 < $signed(SW'(lat_w_r)));
    if (lat_mode_r == MODE_REFLECT) begin
      ri = refl(row_c, SW'(ta_r), $signed(SW'(lat_h_r)));
      ci = refl(col_c, SW'(tb_r), $signed(SW'(lat_w_r)));
    end else begin
      ri = ri0;
      ci = ci0;
    end
    use_tap = (lat_mode_r == MODE_REFLECT) || (in_r && in_c);
    // reflected rows stay within the radius, so the ring slot is a short wrap
    roff = ri - row_c;
    rs   = $signed(RS_W'(o_ring_r)) + RS_W'(roff);
    if (rs < 0)                         rs = rs + RS_W'(TAPS);
    else if (rs >= $signed(RS_W'(TAPS))) rs = rs - RS_W'(TAPS);
    ring_idx = rs[RING_W-1:0];
    col_idx  = use_tap ? ci[COL_W-1:0] : '0;
    ma = (ta_r < 0) ? MAG_W'(-ta_r) : MAG_W'(ta_r);
    mb = (tb_r < 0) ? MAG_W'(-tb_r) : MAG_W'(tb_r);
  end

  always_comb begin
    dsh = NUM_W'(den_r) << k_r;
    sh  = num_r >> PROD_W;
    case (lat_mode_r)
      MODE_ZERO, MODE_REFLECT: res = (|sh[NUM_W-1:8]) ? 8'hFF : sh[7:0];
      MODE_RENORM:             res = (den_r == '0) ? 8'd0 : q_r;
      default:                 res = 8'd0;
    endcase
  end

  // line store and tap pipeline data
  always_ff @(posedge clk) begin
    if (pop && q_data.wr) begin
      mem[q_data.wring[RING_W-1:0]][q_data.wcol[COL_W-1:0]] <= q_data.pix;
    end
    rd_r     <= mem[ring_idx][col_idx];
    wp_r     <= PROD_W'(wv_r[ma]) * PROD_W'(wh_r[mb]);
    s1_use_r <= use_tap;
    prod_r   <= s1_use_r ? (PROD_W + 8)'(wp_r) * (PROD_W + 8)'(rd_r) : '0;
    wpd_r    <= s1_use_r ? wp_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      lat_mode_r  <= '0;
      lat_w_r     <= '0;
      lat_h_r     <= '0;
      o_row_r     <= '0;
      o_col_r     <= '0;
      o_ring_r    <= '0;
      o_last_r    <= 1'b0;
      ta_r        <= '0;
      tb_r        <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      num_r       <= '0;
      den_r       <= '0;
      rem_r       <= '0;
      q_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_pix_r   <= '0;
      for (int d = 0; d <= RADIUS; d++) begin
        wv_r[d] <= '0;
        wh_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (pop && q_data.first) begin
        lat_mode_r <= cfg.mode;
        lat_w_r    <= WID_W'(clamp_dim(HEIGHT_W'(cfg.width), HEIGHT_W'(MAX_WIDTH)));
        lat_h_r    <= clamp_dim(cfg.height, HEIGHT_W'(MAX_HEIGHT));
        for (int d = 0; d <= RADIUS; d++) begin
          wv_r[d] <= (d < 4) ? cfg.vert_near[16*(d%4) +: WEIGHT_BITS]
                             : cfg.vert_far[16*(d%4) +: WEIGHT_BITS];
          wh_r[d] <= (d < 4) ? cfg.horz_near[16*(d%4) +: WEIGHT_BITS]
                             : cfg.horz_far[16*(d%4) +: WEIGHT_BITS];
        end
      end
      if (start) begin
        o_row_r  <= q_data.orow;
        o_col_r  <= q_data.ocol[COL_W-1:0];
        o_ring_r <= q_data.oring[RING_W-1:0];
        o_last_r <= q_data.last;
        ta_r     <= R_NEG;
        tb_r     <= R_NEG;
        num_r    <= '0;
        den_r    <= '0;
      end else if (s2_v_r) begin
        num_r <= num_r + NUM_W'(prod_r);
        den_r <= den_r + DEN_W'(wpd_r);
      end
      if (issue) begin
        if (tb_r == R_POS) begin
          tb_r <= R_NEG;
          ta_r <= ta_r + 1'b1;
        end else begin
          tb_r <= tb_r + 1'b1;
        end
      end
      if (state_r == BK_FLUSH && flushed) begin
        rem_r <= num_r;
        q_r   <= '0;
        k_r   <= 3'd7;
      end
      // restoring divide, one quotient bit per cycle; weighted mean never exceeds 255
      if (state_r == BK_DIV) begin
        if (rem_r >= dsh) begin
          rem_r    <= rem_r - dsh;
          q_r[k_r] <= 1'b1;
        end
        k_r <= k_r - 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        out_pix_r   <= res;
        out_last_r  <= o_last_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pix_r;
  assign out_frame_end = out_last_r;

endmodule

// ===== hw/rtl/separable_gaussian_blur_gray_core.sv =====
// Separable Gaussian blur core: grayscale raster in, blurred raster out.
// Pixels enter in raster order; each result for pixel (i,j) is released by the beat at
// raster position (i+RADIUS)*W + j + RADIUS, and RADIUS*W+RADIUS drain beats after the
// frame flush the tail. The front takes one beat per cycle while its 4-deep job queue
// has room. The back runs one job at a time through a single multiply-accumulate
// path: a beat that only stores a pixel is popped and written at once; a beat that
// yields a result steps through all (2*RADIUS+1)^2 window taps, plus an 8-bit restoring
// divide in renormalized mode. The tap loop over the window sets the throughput. The
// line store needs no initialization after reset; only written entries ever reach a result.
module separable_gaussian_blur_gray_core import sgb_pkg::*; #(
  parameter int RADIUS      = RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_pixel_in,
  input  logic                  in_drain,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_out,
  output logic                  out_frame_end
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_ZERO;
      cfg_r.width     <= WIDTH_W'(512);
      cfg_r.height    <= HEIGHT_W'(512);
      cfg_r.vert_near <= '0;
      cfg_r.vert_far  <= '0;
      cfg_r.horz_near <= '0;
      cfg_r.horz_far  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BORDER_MODE: cfg_r.mode      <= cfg_data[MODE_W-1:0];
        REG_WIDTH:       cfg_r.width     <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:      cfg_r.height    <= cfg_data[HEIGHT_W-1:0];
        REG_VERT_NEAR:   cfg_r.vert_near <= cfg_data;
        REG_VERT_FAR:    cfg_r.vert_far  <= cfg_data;
        REG_HORZ_NEAR:   cfg_r.horz_near <= cfg_data;
        REG_HORZ_FAR:    cfg_r.horz_far  <= cfg_data;
        default: ;
      endcase
    end
  end

  sgb_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel_in),
    .in_drain (in_drain),
    .q_push   (q_push),
    .q_data   (q_din),
    .q_full   (q_full)
  );

  sgb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  sgb_back #(
    .RADIUS      (RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_data        (q_dout),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule
